[rtl/mrac_pkg.sv]
// ----------------------------------------------------------------------------
// mrac_pkg
// Types and codes shared by the Modbus response anomaly checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrac_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FWD_ADDR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FWD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BWD     = 3'd4;

  localparam logic [1:0] FUNC_REQUEST = 2'd0;
  localparam logic [1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [1:0] FUNC_POLL    = 2'd2;

  localparam logic [31:0] NO_READING = 32'hFFFF_FFFF;
  localparam logic [6:0]  MIN_BWD_COUNT = 7'd4;
  localparam int          MASK_IDS = 8;

  typedef enum logic [2:0] {
    V_PASS        = 3'd0,
    V_POLL_FAILED = 3'd1,
    V_ROGUE_ID    = 3'd2,
    V_NO_REQUEST  = 3'd3,
    V_DEVICE_LOST = 3'd4,
    V_VALUE_RANGE = 3'd5
  } verdict_t;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic [31:0] fwd;
    logic [31:0] bwd;
  } totals_t;

  typedef struct packed {
    logic        poll_ok;
    logic        known;
    logic        flag;
    logic        late;
    logic        addr_match;
    logic        cnt4;
    logic [31:0] fwd;
    logic [31:0] bwd;
    logic [31:0] last_fwd;
    logic [31:0] last_bwd;
    logic [31:0] max_fwd;
    logic [31:0] max_bwd;
  } check_t;

  typedef struct packed {
    verdict_t verdict;
    logic     wr_en;
    logic     bwd_upd;
  } judge_t;

endpackage

`default_nettype wire

[rtl/mrac_if.sv]
// ----------------------------------------------------------------------------
// mrac_if
// Valid/ready channels of the checker: command words in, verdict words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrac_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  unit_id;
  logic        poll_ok;
  logic [15:0] resp_time;
  logic [15:0] start_reg;
  logic [6:0]  num_regs;
  logic [15:0] word0;
  logic [15:0] word1;
  logic [15:0] word2;
  logic [15:0] word3;

  modport source (
    output valid, func, unit_id, poll_ok, resp_time, start_reg, num_regs,
           word0, word1, word2, word3,
    input  ready
  );
  modport sink (
    input  valid, func, unit_id, poll_ok, resp_time, start_reg, num_regs,
           word0, word1, word2, word3,
    output ready
  );
endinterface

interface mrac_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

`default_nettype wire

[rtl/modbus_response_anomaly_checker.sv]
// ----------------------------------------------------------------------------
// modbus_response_anomaly_checker
// Per-slave request tracking and totalizer checks on Modbus poll responses.
//
//   channel  dir  handshake       word
//   cmd      in   valid/ready     func, unit_id, poll data, word0..word3
//   res      out  valid/ready     verdict (one per poll result)
//   cfg      in   cfg_en          cfg_index, cfg_data
//
// Request and clear words are taken while idle. A poll result is first
// read from the totalizer memory, then checked and written back together.
// While a verdict waits to be taken the checker holds in its check cycle.
// Reset restores register defaults, clears request flags and marks all
// totalizers as no reading; no memory sweep is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_response_anomaly_checker
  import mrac_pkg::*;
#(
  parameter int NUM_SLAVES = 8
) (
  input  wire                  clk,
  input  wire                  rst,
  mrac_cmd_if.sink             cmd,
  mrac_res_if.source           res,
  input  wire                  cfg_en,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_SLAVES > 1) ? $clog2(NUM_SLAVES) : 1;

  logic [7:0]  known_id_mask;
  logic [15:0] resp_window;
  logic [15:0] forward_register_address;
  logic [31:0] max_forward_delta;
  logic [31:0] max_bwd_delta;

  state_t state;
  state_t state_next;

  logic [NUM_SLAVES-1:0] req_flags;
  logic [NUM_SLAVES-1:0] fwd_vld;
  logic [NUM_SLAVES-1:0] bwd_vld;
  totals_t               mem [0:NUM_SLAVES-1];
  totals_t               rdata;

  logic [IDX_W-1:0] cmd_idx;
  logic             in_range;
  logic             known;
  logic             accept;
  logic             done;

  logic [IDX_W-1:0] hold_idx;
  logic             hold_known;
  logic             hold_poll_ok;
  logic [15:0]      hold_time;
  logic [15:0]      hold_addr;
  logic             hold_cnt4;
  logic [31:0]      hold_fwd;
  logic [31:0]      hold_bwd;

  check_t chk;
  judge_t jdg;
  logic   mem_we;

  always_comb begin
    cmd_idx  = IDX_W'(cmd.unit_id - 8'd1);
    in_range = (cmd.unit_id != 8'd0) && (cmd.unit_id <= 8'(NUM_SLAVES));
    known    = in_range && (cmd.unit_id <= 8'(MASK_IDS)) &&
               known_id_mask[3'(cmd.unit_id - 8'd1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      known_id_mask            <= 8'd255;
      resp_window              <= 16'd1000;
      forward_register_address <= 16'd0;
      max_forward_delta        <= 32'd1000;
      max_bwd_delta            <= 32'd10;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_KNOWN_MASK:  known_id_mask            <= cfg_data[7:0];
        CFG_RESP_WINDOW: resp_window              <= cfg_data[15:0];
        CFG_FWD_ADDR:    forward_register_address <= cfg_data[15:0];
        CFG_MAX_FWD:     max_forward_delta        <= cfg_data;
        CFG_MAX_BWD:     max_bwd_delta            <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = (state == ST_IDLE);
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd.valid && cmd.func == FUNC_POLL) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        done = !res.valid || res.ready;
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_flags <= '0;
    end else if (accept) begin
      if (cmd.func == FUNC_REQUEST && in_range) begin
        req_flags[cmd_idx] <= 1'b1;
      end else if (cmd.func == FUNC_CLEAR) begin
        req_flags <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.func == FUNC_POLL) begin
      hold_idx     <= cmd_idx;
      hold_known   <= known;
      hold_poll_ok <= cmd.poll_ok;
      hold_time    <= cmd.resp_time;
      hold_addr    <= cmd.start_reg;
      hold_cnt4    <= (cmd.num_regs >= MIN_BWD_COUNT);
      hold_fwd     <= {cmd.word0, cmd.word1};
      hold_bwd     <= {cmd.word2, cmd.word3};
    end
  end

  // totalizer memory: read on poll accept, write back in check cycle
  always_ff @(posedge clk) begin
    if (accept && cmd.func == FUNC_POLL) begin
      rdata <= mem[cmd_idx];
    end
    if (mem_we) begin
      mem[hold_idx] <= '{fwd: hold_fwd, bwd: jdg.bwd_upd ? hold_bwd : rdata.bwd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= '0;
      bwd_vld <= '0;
    end else if (mem_we) begin
      fwd_vld[hold_idx] <= 1'b1;
      if (jdg.bwd_upd) begin
        bwd_vld[hold_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    chk.poll_ok    = hold_poll_ok;
    chk.known      = hold_known;
    chk.flag       = req_flags[hold_idx];
    chk.late       = hold_time > resp_window;
    chk.addr_match = hold_addr == forward_register_address;
    chk.cnt4       = hold_cnt4;
    chk.fwd        = hold_fwd;
    chk.bwd        = hold_bwd;
    chk.last_fwd   = fwd_vld[hold_idx] ? rdata.fwd : NO_READING;
    chk.last_bwd   = bwd_vld[hold_idx] ? rdata.bwd : NO_READING;
    chk.max_fwd    = max_forward_delta;
    chk.max_bwd    = max_bwd_delta;
  end

  mrac_judge u_judge (
    .chk (chk),
    .jdg (jdg)
  );

  assign mem_we = done && jdg.wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (done) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res.verdict <= jdg.verdict;
    end
  end

  a_res_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == ST_CHECK))
    else $error("verdict raised without a check cycle");

  a_we_in_check: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CHECK) && hold_known && hold_poll_ok)
    else $error("totalizer write outside a passing check");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> fwd_vld[$past(hold_idx)])
    else $error("written totalizer not marked valid");

  a_no_accept_in_check: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> !cmd.ready)
    else $error("command accepted during check");

endmodule

`default_nettype wire

[rtl/mrac_judge.sv]
// ----------------------------------------------------------------------------
// mrac_judge
// Verdict priority and totalizer delta checks for one poll result.
// ----------------------------------------------------------------------------
`default_nettype none

module mrac_judge
  import mrac_pkg::*;
(
  input  check_t chk,
  output judge_t jdg
);

  logic [32:0] fwd_diff;
  logic [32:0] bwd_diff;
  logic        fwd_bad;
  logic        bwd_bad;

  always_comb begin
    fwd_diff = {1'b0, chk.fwd} - {1'b0, chk.last_fwd};
    bwd_diff = {1'b0, chk.bwd} - {1'b0, chk.last_bwd};
    fwd_bad  = (chk.last_fwd != NO_READING) &&
               (fwd_diff[32] || (fwd_diff[31:0] > chk.max_fwd));
    bwd_bad  = chk.cnt4 && (chk.last_bwd != NO_READING) &&
               (bwd_diff[32] || (bwd_diff[31:0] >= chk.max_bwd));

    jdg.wr_en   = 1'b0;
    jdg.bwd_upd = chk.cnt4;
    if (!chk.poll_ok) begin
      jdg.verdict = V_POLL_FAILED;
    end else if (!chk.known) begin
      jdg.verdict = V_ROGUE_ID;
    end else if (!chk.flag) begin
      jdg.verdict = V_NO_REQUEST;
    end else if (chk.late) begin
      jdg.verdict = V_DEVICE_LOST;
    end else if (!chk.addr_match) begin
      jdg.verdict = V_PASS;
    end else if (fwd_bad || bwd_bad) begin
      jdg.verdict = V_VALUE_RANGE;
    end else begin
      jdg.verdict = V_PASS;
      jdg.wr_en   = 1'b1;
    end
  end

endmodule

`default_nettype wire
